// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types and constants for the unpadded base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // run status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_BOUNDS = 2'd2;

  // configuration register indexes
  localparam logic CFG_BYTE_CAPACITY = 1'b0;
  localparam logic CFG_SYMBOL_LIMIT  = 1'b1;

  localparam int CfgWidth = 13;

  localparam logic [11:0] BYTE_CAPACITY_RESET = 12'd2048;
  localparam logic [12:0] SYMBOL_LIMIT_RESET  = 13'd2731;

  // result queue, a power of two
  localparam int QueueDepth = 8;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueLvlW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_data;
    logic        run_end;
    logic [1:0]  status;
    logic [11:0] byte_total;
  } b64d_result_t;

  // results produced by one character, at most three
  typedef struct packed {
    logic [1:0]             count;
    b64d_result_t [2:0]     res;
  } b64d_push_t;

  typedef struct packed {
    logic                 room;
    logic [QueueLvlW-1:0] level;
  } b64d_queue_status_t;

endpackage

// ===== hw/rtl/base64url_decoder_unpadded.sv =====
// ----------------------------------------------------------------------------
// base64url_decoder_unpadded
// Unpadded URL-safe base64 decoder, one character per transaction.
// ----------------------------------------------------------------------------
// A character is taken in every cycle while the eight-entry result queue has
// room for three results. Each character is decoded combinationally from its
// input register and drops zero to three results into the queue; its first
// result is offered after the input register and the queue. Results leave at
// one per cycle unless stalled. A complete group gives three results for every
// four characters, so with a free output side it keeps up one character per
// cycle; only a stalled output fills the queue and holds the input back.
// Slashes are skipped; the final result of a string carries run_end, the
// status and the byte count, and errors hold until the final character.
// Registers: index 0 byte_capacity, index 1 symbol_limit.
module base64url_decoder_unpadded #(
  parameter int MAX_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        final_char,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  data_byte,
  output logic        has_data,
  output logic        run_end,
  output logic [1:0]  status,
  output logic [11:0] byte_total
);
  import b64d_pkg::*;

  b64d_push_t         push;
  b64d_queue_status_t queue_status;
  b64d_result_t       head;
  logic               hold_valid;

  b64d_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_code    (char_code),
    .final_char   (final_char),
    .queue_status (queue_status),
    .push         (push),
    .hold_valid   (hold_valid)
  );

  b64d_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .pop          (!result_stall),
    .not_empty    (result_valid),
    .head         (head),
    .queue_status (queue_status)
  );

  assign data_byte  = head.data_byte;
  assign has_data   = head.has_data;
  assign run_end    = head.run_end;
  assign status     = head.status;
  assign byte_total = head.byte_total;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    queue_status.level <= QueueLvlW'(QueueDepth))
    else $error("result queue overflow");

  // a push only happens from a held character with queue room
  a_push_ok: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (hold_valid && queue_status.room))
    else $error("push without held character or room");

  // a data-less end result with ok status still reports decoded bytes
  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && run_end && !has_data && status == ST_OK) |-> (byte_total != 12'd0))
    else $error("data-less ok end result with no bytes");

  // an error result carries no byte count and closes the string
  a_error_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (run_end && !has_data && byte_total == 12'd0))
    else $error("malformed error result");

endmodule

// ===== hw/rtl/b64d_core.sv =====
// ----------------------------------------------------------------------------
// b64d_core
// Character register, run state and single-pass symbol decode; produces up
// to three results per character for the result queue.
// ----------------------------------------------------------------------------
module b64d_core #(
  parameter int MAX_BYTES = 2048
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [b64d_pkg::CfgWidth-1:0] cfg_data,
  input  logic                         char_valid,
  output logic                         char_stall,
  input  logic [7:0]                   char_code,
  input  logic                         final_char,
  input  b64d_pkg::b64d_queue_status_t queue_status,
  output b64d_pkg::b64d_push_t         push,
  output logic                         hold_valid
);
  import b64d_pkg::*;

  localparam int MaxW = ($clog2(MAX_BYTES + 1) > 13) ? $clog2(MAX_BYTES + 1) : 13;
  localparam logic [MaxW-1:0] MaxBytesV = MaxW'(MAX_BYTES);

  localparam logic [7:0] CharSlash = 8'h2F;

  logic [11:0] byte_capacity;
  logic [12:0] symbol_limit;

  logic [7:0]  hold_char;
  logic        hold_fin;

  logic [17:0] sextet_buffer, sextet_buffer_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [12:0] symbols_seen, symbols_seen_next;
  logic [11:0] bytes_out, bytes_out_next;
  logic [1:0]  error_code, error_code_next;

  logic        advance;
  logic        accept;
  logic [6:0]  sym;
  logic [23:0] word;
  logic [1:0]  nb;
  logic [1:0]  tail;
  logic [7:0]  bytes [3];
  logic        last;
  b64d_push_t  push_calc;

  // {valid, value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic room_for(input logic [11:0] used, input logic [11:0] cap,
                                    input logic [1:0] n);
    logic [12:0] sum;
    sum = {1'b0, used} + {11'd0, n};
    return (sum <= {1'b0, cap}) && (MaxW'(sum) <= MaxBytesV);
  endfunction

  assign advance    = hold_valid && queue_status.room;
  assign char_stall = hold_valid && !queue_status.room;
  assign accept     = char_valid && !char_stall;

  always_comb begin
    sextet_buffer_next = sextet_buffer;
    group_fill_next    = group_fill;
    symbols_seen_next  = symbols_seen;
    bytes_out_next     = bytes_out;
    error_code_next    = error_code;
    nb                 = 2'd0;
    tail               = 2'd0;
    last               = 1'b0;
    bytes[0]           = '0;
    bytes[1]           = '0;
    bytes[2]           = '0;
    sym                = sextet_of(hold_char);
    word               = {sextet_buffer, sym[5:0]};
    push_calc          = '0;

    if (error_code == ST_OK && hold_char != CharSlash) begin
      if (!sym[6]) begin
        error_code_next = ST_FORMAT;
      end else if ({1'b0, symbols_seen} + 14'd1 > {1'b0, symbol_limit}) begin
        error_code_next = ST_BOUNDS;
      end else begin
        symbols_seen_next = symbols_seen + 13'd1;
        if (group_fill == 2'd3) begin
          if (!room_for(bytes_out, byte_capacity, 2'd3)) begin
            error_code_next = ST_BOUNDS;
          end else begin
            bytes[0]       = word[23:16];
            bytes[1]       = word[15:8];
            bytes[2]       = word[7:0];
            nb             = 2'd3;
            bytes_out_next = bytes_out + 12'd3;
          end
          sextet_buffer_next = '0;
          group_fill_next    = 2'd0;
        end else begin
          sextet_buffer_next = {sextet_buffer[11:0], sym[5:0]};
          group_fill_next    = group_fill + 2'd1;
        end
      end
    end

    // tail of the string: a partial group gives one or two bytes
    if (hold_fin && error_code_next == ST_OK && nb == 2'd0) begin
      if (group_fill_next == 2'd1 || symbols_seen_next == 13'd0) begin
        error_code_next = ST_FORMAT;
      end else if (group_fill_next >= 2'd2) begin
        tail = group_fill_next - 2'd1;
        if (!room_for(bytes_out, byte_capacity, tail)) begin
          error_code_next = ST_BOUNDS;
        end else begin
          if (group_fill_next == 2'd2) begin
            bytes[0] = sextet_buffer_next[11:4];
            nb       = 2'd1;
          end else begin
            bytes[0] = sextet_buffer_next[17:10];
            bytes[1] = sextet_buffer_next[9:2];
            nb       = 2'd2;
          end
          bytes_out_next = bytes_out + {10'd0, tail};
        end
      end
      if (error_code_next == ST_OK && bytes_out_next == 12'd0) begin
        error_code_next = ST_FORMAT;
      end
    end

    if (!hold_fin) begin
      push_calc.count = nb;
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < nb) begin
          push_calc.res[k].data_byte = bytes[k];
          push_calc.res[k].has_data  = 1'b1;
        end
      end
    end else if (error_code_next != ST_OK || nb == 2'd0) begin
      push_calc.count             = 2'd1;
      push_calc.res[0].run_end    = 1'b1;
      push_calc.res[0].status     = error_code_next;
      push_calc.res[0].byte_total = (error_code_next == ST_OK) ? bytes_out_next : 12'd0;
    end else begin
      push_calc.count = nb;
      for (int k = 0; k < 3; k++) begin
        last = (2'(k) == nb - 2'd1);
        if (2'(k) < nb) begin
          push_calc.res[k].data_byte  = bytes[k];
          push_calc.res[k].has_data   = 1'b1;
          push_calc.res[k].run_end    = last;
          push_calc.res[k].status     = ST_OK;
          push_calc.res[k].byte_total = last ? bytes_out_next : 12'd0;
        end
      end
    end

    if (!advance) begin
      push_calc.count = 2'd0;
    end
  end

  assign push = push_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_capacity <= BYTE_CAPACITY_RESET;
      symbol_limit  <= SYMBOL_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BYTE_CAPACITY: byte_capacity <= cfg_data[11:0];
        CFG_SYMBOL_LIMIT:  symbol_limit  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_char <= char_code;
      hold_fin  <= final_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      sextet_buffer <= '0;
      group_fill    <= '0;
      symbols_seen  <= '0;
      bytes_out     <= '0;
      error_code    <= ST_OK;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        if (hold_fin) begin
          // string done, back to a clean run
          sextet_buffer <= '0;
          group_fill    <= '0;
          symbols_seen  <= '0;
          bytes_out     <= '0;
          error_code    <= ST_OK;
        end else begin
          sextet_buffer <= sextet_buffer_next;
          group_fill    <= group_fill_next;
          symbols_seen  <= symbols_seen_next;
          bytes_out     <= bytes_out_next;
          error_code    <= error_code_next;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Result queue: takes up to three results a cycle, hands out one when popped.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  b64d_pkg::b64d_push_t          push,
  input  logic                          pop,
  output logic                          not_empty,
  output b64d_pkg::b64d_result_t        head,
  output b64d_pkg::b64d_queue_status_t  queue_status
);
  import b64d_pkg::*;

  b64d_result_t mem [QueueDepth];

  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueLvlW-1:0] level;
  logic                 pop_ok;

  assign not_empty          = (level != '0);
  assign pop_ok             = pop && not_empty;
  assign head               = mem[rd_ptr];
  assign queue_status.level = level;
  // room for the largest burst of one character
  assign queue_status.room  = (level <= QueueLvlW'(QueueDepth - 3));

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.count) begin
        mem[wr_ptr + QueuePtrW'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QueuePtrW'(push.count);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + QueuePtrW'(1);
      end
      level <= level + QueueLvlW'(push.count) - QueueLvlW'(pop_ok);
    end
  end

endmodule
